// ----- rtl/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared widths and command codes for the Cartesian PD force block.
// ----------------------------------------------------------------------------
package cpf_pkg;

	localparam int OPA_W  = 34;
	localparam int OPB_W  = 33;
	localparam int PROD_W = OPA_W + OPB_W;

	localparam logic [1:0] CMD_POSE   = 2'd0;
	localparam logic [1:0] CMD_VEL    = 2'd1;
	localparam logic [1:0] CMD_TARGET = 2'd2;
	localparam logic [1:0] CMD_TICK   = 2'd3;

	typedef logic signed [OPA_W-1:0]  opa_t;
	typedef logic signed [OPB_W-1:0]  opb_t;
	typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ----- rtl/cpf_if.sv -----
// ----------------------------------------------------------------------------
// cpf_if
// Valid/ready channels: input items and force results.
// ----------------------------------------------------------------------------
interface cpf_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	modport source (output valid, cmd, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
		input ready);
	modport sink (input valid, cmd, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
		output ready);
endinterface

interface cpf_force_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	modport source (output valid, force_x, force_y, force_z, input ready);
	modport sink (input valid, force_x, force_y, force_z, output ready);
endinterface

// ----- rtl/cartesian_pd_force_in_tool_frame.sv -----
// ----------------------------------------------------------------------------
// cartesian_pd_force_in_tool_frame
// Cartesian PD force controller, result rotated into the tool frame.
//
//  channel   dir  payload                                   transfer when
//  item_in   in   cmd, vec_x/y/z, quat_x/y/z/w              valid & ready
//  force_out out  force_x/y/z                               valid & ready
//  cfg       in   cfg_we, cfg_idx, cfg_data                 cfg_we high
//
// Pose, velocity and target items are registered on transfer.
// A tick runs on the shared multiplier (9 quaternion products, 6 gain products,
// 9 rotation products), then the result loads the output register. item_in is
// not ready while a tick runs, or while its finished result waits for a full
// output register to drain.
// Reset: gains 1.0, measured state zero, target (-0.35, 0, -0.14).
// ----------------------------------------------------------------------------
module cartesian_pd_force_in_tool_frame (
	input  logic        clk,
	input  logic        arst_n,
	cpf_item_if.sink    item_in,
	cpf_force_if.source force_out,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data
);
	import cpf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// op schedule on the step counter
	localparam logic [4:0] OP_GAIN0 = 5'd9;
	localparam logic [4:0] OP_ROT0  = 5'd15;
	localparam logic [4:0] OP_LAST  = 5'd23;
	localparam logic [4:0] STEP_END = 5'd24;

	localparam logic cfg_kp = 1'b0;
	localparam logic cfg_kd = 1'b1;

	// negate with the most negative value clipped
	function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
		neg32 = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
	endfunction

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		neg16 = (v == 16'sh8000) ? 16'sh7fff : -v;
	endfunction

	// round half away from zero by 16 bits
	function automatic logic signed [51:0] rnd16(input prod_t v);
		logic [PROD_W-1:0] m;
		logic [51:0]       t;
		m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		m = (m + PROD_W'(32768)) >> 16;
		t = m[51:0];
		rnd16 = v[PROD_W-1] ? -$signed(t) : $signed(t);
	endfunction

	// round half away from zero by 24 bits
	function automatic logic signed [51:0] rnd24(input logic signed [61:0] v);
		logic [61:0] m;
		logic [51:0] t;
		m = v[61] ? 62'(-v) : 62'(v);
		m = (m + 62'(24'h80_0000)) >> 24;
		t = m[51:0];
		rnd24 = v[61] ? -$signed(t) : $signed(t);
	endfunction

	// rotation entry Q.28 to Q.24
	function automatic opa_t rnd4(input logic signed [35:0] v);
		logic [35:0] m;
		logic [33:0] t;
		m = v[35] ? 36'(-v) : 36'(v);
		m = (m + 36'd8) >> 4;
		t = m[33:0];
		rnd4 = v[35] ? -$signed(t) : $signed(t);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v > 52'sd2147483647)
			sat32 = 32'sh7fff_ffff;
		else if (v < -52'sd2147483648)
			sat32 = 32'sh8000_0000;
		else
			sat32 = v[31:0];
	endfunction

	logic [31:0]        kp_q, kd_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] tgt_q [3];
	logic signed [15:0] quat_q [4];

	logic [1:0]         state_q;
	logic [4:0]         step_q;
	logic signed [31:0] prod_q [9];
	logic signed [51:0] pterm_q;
	logic signed [31:0] f_q [3];
	logic signed [61:0] acc_q;
	logic signed [31:0] res_q [3];

	opa_t  mul_a;
	opb_t  mul_b;
	prod_t mul_p;

	cpf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	logic in_xfer, out_xfer;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_xfer  = item_in.valid && item_in.ready;
	assign out_xfer = force_out.valid && force_out.ready;

	// rotation matrix from stored quaternion products
	logic signed [35:0] pe [9];
	opa_t rm [3][3];
	always_comb begin
		for (int k = 0; k < 9; k++)
			pe[k] = 36'(prod_q[k]);
		// products: xx yy zz xy xz yz xw yw zw
		rm[0][0] = rnd4(36'sh1000_0000 - 36'(2 * (pe[1] + pe[2])));
		rm[0][1] = rnd4(36'(2 * (pe[3] - pe[8])));
		rm[0][2] = rnd4(36'(2 * (pe[4] + pe[7])));
		rm[1][0] = rnd4(36'(2 * (pe[3] + pe[8])));
		rm[1][1] = rnd4(36'sh1000_0000 - 36'(2 * (pe[0] + pe[2])));
		rm[1][2] = rnd4(36'(2 * (pe[5] - pe[6])));
		rm[2][0] = rnd4(36'(2 * (pe[4] - pe[7])));
		rm[2][1] = rnd4(36'(2 * (pe[5] + pe[6])));
		rm[2][2] = rnd4(36'sh1000_0000 - 36'(2 * (pe[0] + pe[1])));
	end

	// rotated-frame PD vector: (-f1, f0, f2)
	opb_t gv [3];
	assign gv[0] = -opb_t'(f_q[1]);
	assign gv[1] = opb_t'(f_q[0]);
	assign gv[2] = opb_t'(f_q[2]);

	// operand select for the op issued this step
	logic [3:0] iss_g, iss_r;
	logic [1:0] iss_ax, iss_i, iss_j;
	always_comb begin
		iss_g  = 4'(step_q - OP_GAIN0);
		iss_r  = 4'(step_q - OP_ROT0);
		iss_ax = iss_g[2:1];
		iss_i  = (iss_r >= 4'd6) ? 2'd2 : (iss_r >= 4'd3) ? 2'd1 : 2'd0;
		iss_j  = 2'(iss_r - 4'(3 * iss_i));
		mul_a  = '0;
		mul_b  = '0;
		case (step_q)
			5'd0: begin mul_a = opa_t'(quat_q[0]); mul_b = opb_t'(quat_q[0]); end
			5'd1: begin mul_a = opa_t'(quat_q[1]); mul_b = opb_t'(quat_q[1]); end
			5'd2: begin mul_a = opa_t'(quat_q[2]); mul_b = opb_t'(quat_q[2]); end
			5'd3: begin mul_a = opa_t'(quat_q[0]); mul_b = opb_t'(quat_q[1]); end
			5'd4: begin mul_a = opa_t'(quat_q[0]); mul_b = opb_t'(quat_q[2]); end
			5'd5: begin mul_a = opa_t'(quat_q[1]); mul_b = opb_t'(quat_q[2]); end
			5'd6: begin mul_a = opa_t'(quat_q[0]); mul_b = opb_t'(quat_q[3]); end
			5'd7: begin mul_a = opa_t'(quat_q[1]); mul_b = opb_t'(quat_q[3]); end
			5'd8: begin mul_a = opa_t'(quat_q[2]); mul_b = opb_t'(quat_q[3]); end
			default: begin
				if (step_q < OP_ROT0) begin
					if (iss_g[0]) begin
						mul_a = opa_t'(vel_q[iss_ax]);
						mul_b = opb_t'({1'b0, kd_q});
					end else begin
						mul_a = opa_t'(tgt_q[iss_ax]) - opa_t'(pos_q[iss_ax]);
						mul_b = opb_t'({1'b0, kp_q});
					end
				end else if (step_q <= OP_LAST) begin
					mul_a = rm[iss_j][iss_i];
					mul_b = gv[iss_j];
				end
			end
		endcase
	end

	// decode of the op whose product arrives this step
	logic [4:0] con;
	logic [3:0] con_g, con_r;
	logic [1:0] con_ax, con_i, con_j;
	logic signed [51:0] gterm;
	logic signed [61:0] acc_nx;
	always_comb begin
		con    = step_q - 5'd1;
		con_g  = 4'(con - OP_GAIN0);
		con_r  = 4'(con - OP_ROT0);
		con_ax = con_g[2:1];
		con_i  = (con_r >= 4'd6) ? 2'd2 : (con_r >= 4'd3) ? 2'd1 : 2'd0;
		con_j  = 2'(con_r - 4'(3 * con_i));
		gterm  = rnd16(mul_p);
		acc_nx = ((con_j == 2'd0) ? 62'sd0 : acc_q) + mul_p[61:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && step_q != 5'd0) begin
			if (con < OP_GAIN0)
				prod_q[con[3:0]] <= mul_p[31:0];
			else if (con < OP_ROT0) begin
				if (!con_g[0])
					pterm_q <= gterm;
				else
					f_q[con_ax] <= sat32(pterm_q - gterm);
			end else begin
				acc_q <= acc_nx;
				if (con_j == 2'd2)
					res_q[con_i] <= sat32(rnd24(acc_nx));
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_xfer && item_in.cmd == CMD_TICK)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == STEP_END)
						state_q <= ST_DONE;
					else
						step_q <= step_q + 5'd1;
				end
				ST_DONE: begin
					if (!force_out.valid || force_out.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			force_out.valid <= 1'b0;
		else if (state_q == ST_DONE && (!force_out.valid || force_out.ready))
			force_out.valid <= 1'b1;
		else if (out_xfer)
			force_out.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!force_out.valid || force_out.ready)) begin
			force_out.force_x <= res_q[0];
			force_out.force_y <= res_q[1];
			force_out.force_z <= res_q[2];
		end
	end

	// stored state and gains; measured values remapped to (y, -x, z)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= 32'h0001_0000;
			kd_q <= 32'h0001_0000;
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
				vel_q[k] <= '0;
			end
			for (int k = 0; k < 4; k++)
				quat_q[k] <= '0;
			tgt_q[0] <= -32'sd22938;
			tgt_q[1] <= '0;
			tgt_q[2] <= -32'sd9175;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					cfg_kp: kp_q <= cfg_data;
					cfg_kd: kd_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				case (item_in.cmd)
					CMD_POSE: begin
						pos_q[0]  <= item_in.vec_y;
						pos_q[1]  <= neg32(item_in.vec_x);
						pos_q[2]  <= item_in.vec_z;
						quat_q[0] <= item_in.quat_y;
						quat_q[1] <= neg16(item_in.quat_x);
						quat_q[2] <= item_in.quat_z;
						quat_q[3] <= item_in.quat_w;
					end
					CMD_VEL: begin
						vel_q[0] <= item_in.vec_y;
						vel_q[1] <= neg32(item_in.vec_x);
						vel_q[2] <= item_in.vec_z;
					end
					CMD_TARGET: begin
						tgt_q[0] <= item_in.vec_x;
						tgt_q[1] <= item_in.vec_y;
						tgt_q[2] <= item_in.vec_z;
					end
					default: ;
				endcase
			end
		end
	end

	// checks
	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && item_in.cmd == CMD_TICK) |=> (state_q == ST_RUN && step_q == 5'd0))
		else $error("tick did not start the sequencer");
	a_other_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && item_in.cmd != CMD_TICK) |=> state_q == ST_IDLE)
		else $error("state item left idle");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= STEP_END)
		else $error("step counter overran");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && force_out.valid && !force_out.ready) |=> state_q == ST_DONE)
		else $error("result dropped while output full");
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == STEP_END) |=> state_q == ST_DONE)
		else $error("run did not finish");

endmodule

// ----- rtl/cpf_mul.sv -----
// ----------------------------------------------------------------------------
// cpf_mul
// Shared signed multiplier, product registered.
// ----------------------------------------------------------------------------
module cpf_mul (
	input  logic          clk,
	input  cpf_pkg::opa_t a,
	input  cpf_pkg::opb_t b,
	output cpf_pkg::prod_t p
);
	import cpf_pkg::*;

	always_ff @(posedge clk) begin
		p <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
